// ----- design/gcdm_pkg.sv -----
// ----------------------------------------------------------------------------
// gcdm_pkg
// Shared constants for the chessboard distance maximum block: default grid
// limits, configuration register indexes and result encodings.
// ----------------------------------------------------------------------------
package gcdm_pkg;

    // default grid limits
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // distance width for the default limits (values 0..63, all ones = unreached)
    localparam int DIST_W_DEF = 7;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;

    // register reset value
    localparam int DIM_RESET = 64;

    // result encoding
    localparam int OUT_W = 7;
    localparam logic [OUT_W-1:0] OUT_NONE = 7'h7F;
    localparam int OUT_CAP = 63;

endpackage

// ----- design/gcdm_ram.sv -----
// ----------------------------------------------------------------------------
// gcdm_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module gcdm_ram #(
    parameter int WIDTH = gcdm_pkg::DIST_W_DEF,
    parameter int DEPTH = gcdm_pkg::MAX_ROWS_DEF * gcdm_pkg::MAX_COLS_DEF
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/gcdm_cell.sv -----
// ----------------------------------------------------------------------------
// gcdm_cell
// One cell of the row line: holds one distance and either takes its upper
// neighbor's value or, at the entry point of the line, the fresh distance.
// ----------------------------------------------------------------------------
module gcdm_cell #(
    parameter int DW = gcdm_pkg::DIST_W_DEF
) (
    input  logic          clk,
    input  logic          shift_en,
    input  logic          inject,
    input  logic [DW-1:0] din,
    input  logic [DW-1:0] nbr,
    output logic [DW-1:0] q
);

    logic [DW-1:0] q_reg;
    logic [DW-1:0] q_next;

    // take the fresh value at the entry point, else advance from the neighbor
    assign q_next = inject ? din : nbr;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ----- design/grid_chessboard_distance_max_core.sv -----
// ----------------------------------------------------------------------------
// grid_chessboard_distance_max_core
// Loads a rows x cols binary grid one cell per transfer, then runs a forward
// and a backward chessboard distance sweep and reports the largest distance
// from an empty cell to its nearest marked cell (-1 if none).
// Timing: a frame of N = rows*cols cells loads one cell per cycle; after the
//   final cell's transfer the frame passes through the forward sweep, a
//   turnaround, the backward sweep, a drain and a hand-off step before the
//   result enters the output register (the hand-off waits on out_stall).
// Throughput: a new frame is not taken until the result is handed off; the
//   input stalls through both sweeps, which walk the frame one cell per
//   cycle, and until the output register takes the result.
// Reset: control, load position and grid size registers clear at once
//   (size back to 64 x 64); the grid and distance RAMs are not cleared.
// ----------------------------------------------------------------------------
module grid_chessboard_distance_max_core #(
    parameter int MAX_ROWS = gcdm_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gcdm_pkg::MAX_COLS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [gcdm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gcdm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // cell input
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                cell_marked,
    input  logic                                last_cell,
    // result output
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [gcdm_pkg::OUT_W-1:0]   max_distance
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int CAP    = MAX_ROWS * MAX_COLS;
    localparam int AW     = (CAP > 1) ? $clog2(CAP) : 1;   // RAM address
    localparam int PW     = $clog2(CAP + 1);               // load position, holds CAP
    localparam int RW     = $clog2(MAX_ROWS + 1);          // row count / row index
    localparam int CW     = $clog2(MAX_COLS + 1);          // col count / col index
    localparam int MAXDIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int DW     = $clog2(MAXDIM) + 1;            // distance, all ones = unreached
    localparam int NCELL  = MAX_COLS + 2;                  // row line length, at least 3
    localparam int ROWS_RST = (gcdm_pkg::DIM_RESET > MAX_ROWS) ? MAX_ROWS
                                                               : gcdm_pkg::DIM_RESET;
    localparam int COLS_RST = (gcdm_pkg::DIM_RESET > MAX_COLS) ? MAX_COLS
                                                               : gcdm_pkg::DIM_RESET;
    localparam logic [DW-1:0] FAR = {DW{1'b1}};

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // loading cells
    localparam logic [2:0] S_FWD  = 3'd1;  // forward sweep, raster order
    localparam logic [2:0] S_GAP  = 3'd2;  // let the last forward write land
    localparam logic [2:0] S_BWD  = 3'd3;  // backward sweep, reverse raster order
    localparam logic [2:0] S_FIN  = 3'd4;  // last backward cell in the compute stage
    localparam logic [2:0] S_POST = 3'd5;  // hand the result to the output register

    // position flags of the cell in the compute stage
    typedef struct packed {
        logic valid;
        logic fwd;    // forward sweep
        logic edge_v; // no row on the far side (top row forward, bottom row backward)
        logic lo;     // column zero
        logic hi;     // last column
    } step_flags_t;

    // ------------------------------------------------------------------
    // Configuration: store the grid size already clamped to 1..MAX
    // ------------------------------------------------------------------
    logic [RW-1:0] rows_reg, rows_next;
    logic [CW-1:0] cols_reg, cols_next;

    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_we && (cfg_index == gcdm_pkg::CFG_GRID_ROWS))
        begin
            if (cfg_wdata == '0)
                rows_next = RW'(1);
            else if (32'(cfg_wdata) > MAX_ROWS)
                rows_next = RW'(MAX_ROWS);
            else
                rows_next = RW'(cfg_wdata);
        end
        if (cfg_we && (cfg_index == gcdm_pkg::CFG_GRID_COLS))
        begin
            if (cfg_wdata == '0)
                cols_next = CW'(1);
            else if (32'(cfg_wdata) > MAX_COLS)
                cols_next = CW'(MAX_COLS);
            else
                cols_next = CW'(cfg_wdata);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and sweep counters
    // ------------------------------------------------------------------
    logic [2:0]    state_reg, state_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [RW-1:0] r_reg, r_next;
    logic [CW-1:0] c_reg, c_next;
    step_flags_t   b_reg, b_next;
    logic [AW-1:0] b_addr_reg, b_addr_next;

    logic [DW-1:0] best_reg, best_next;
    logic          any_empty_reg, any_empty_next;
    logic          out_valid_reg, out_valid_next;
    logic [gcdm_pkg::OUT_W-1:0] out_data_reg, out_data_next;

    logic          in_xfer;
    logic          out_xfer;
    logic          cell_we;
    logic          r_first, r_last, c_first, c_last;

    // compute stage
    logic          cell_rd;
    logic [DW-1:0] dist_rd;
    logic [DW-1:0] left_reg;
    logic [DW-1:0] chain_q [NCELL];
    logic [DW-1:0] base_d, cand_v, cand_0, cand_2, cand_s, d_new;
    logic          m0, m2;
    logic [gcdm_pkg::OUT_W-1:0] result;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;

    assign r_first = (r_reg == '0);
    assign r_last  = (r_reg == (rows_reg - RW'(1)));
    assign c_first = (c_reg == '0);
    assign c_last  = (c_reg == (cols_reg - CW'(1)));

    // drop cells past the store capacity
    assign cell_we = in_xfer && (32'(pos_reg) < CAP);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        addr_next      = addr_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        b_next         = '0;
        b_addr_next    = addr_reg;
        best_next      = best_reg;
        any_empty_next = any_empty_reg;
        out_valid_next = out_xfer ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (cell_we)
                        pos_next = pos_reg + PW'(1);
                    if (last_cell)
                    begin
                        // start a new frame sweep at the top-left corner
                        pos_next       = '0;
                        addr_next      = '0;
                        r_next         = '0;
                        c_next         = '0;
                        best_next      = '0;
                        any_empty_next = 1'b0;
                        state_next     = S_FWD;
                    end
                end
            end

            S_FWD:
            begin
                b_next.valid  = 1'b1;
                b_next.fwd    = 1'b1;
                b_next.edge_v = r_first;
                b_next.lo     = c_first;
                b_next.hi     = c_last;
                if (r_last && c_last)
                begin
                    // hold the address: the backward sweep starts here
                    state_next = S_GAP;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                    if (c_last)
                    begin
                        c_next = '0;
                        r_next = r_reg + RW'(1);
                    end
                    else
                    begin
                        c_next = c_reg + CW'(1);
                    end
                end
            end

            S_GAP:
            begin
                state_next = S_BWD;
            end

            S_BWD:
            begin
                b_next.valid  = 1'b1;
                b_next.fwd    = 1'b0;
                b_next.edge_v = r_last;
                b_next.lo     = c_first;
                b_next.hi     = c_last;
                if (r_first && c_first)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    addr_next = addr_reg - AW'(1);
                    if (c_first)
                    begin
                        c_next = cols_reg - CW'(1);
                        r_next = r_reg - RW'(1);
                    end
                    else
                    begin
                        c_next = c_reg - CW'(1);
                    end
                end
            end

            S_FIN:
            begin
                state_next = S_POST;
            end

            S_POST:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = result;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // track the farthest empty cell as the backward sweep finalizes it
        if (b_reg.valid && !b_reg.fwd && !cell_rd)
        begin
            any_empty_next = 1'b1;
            if (d_new > best_reg)
                best_next = d_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            rows_reg      <= RW'(ROWS_RST);
            cols_reg      <= CW'(COLS_RST);
            b_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            b_reg         <= b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        r_reg         <= r_next;
        c_reg         <= c_next;
        b_addr_reg    <= b_addr_next;
        best_reg      <= best_next;
        any_empty_reg <= any_empty_next;
        out_data_reg  <= out_data_next;
        if (b_reg.valid)
            left_reg <= d_new;
    end

    // ------------------------------------------------------------------
    // Grid and forward-distance stores
    // ------------------------------------------------------------------
    gcdm_ram #(
        .WIDTH (1),
        .DEPTH (CAP)
    ) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (pos_reg[AW-1:0]),
        .wdata (cell_marked),
        .raddr (addr_reg),
        .rdata (cell_rd)
    );

    gcdm_ram #(
        .WIDTH (DW),
        .DEPTH (CAP)
    ) u_dist_ram (
        .clk   (clk),
        .we    (b_reg.valid && b_reg.fwd),
        .waddr (b_addr_reg),
        .wdata (d_new),
        .raddr (addr_reg),
        .rdata (dist_rd)
    );

    // ------------------------------------------------------------------
    // Row line: a chain of cells delaying each distance by cols + 1 steps.
    // New values enter at cell cols; cell 0..2 then hold the three
    // neighbors in the previous row (next row in the backward sweep).
    // ------------------------------------------------------------------
    for (genvar k = 0; k < NCELL; k++)
    begin : g_line
        logic [DW-1:0] nbr;
        if (k == NCELL - 1)
        begin : g_top
            assign nbr = d_new;
        end
        else
        begin : g_mid
            assign nbr = chain_q[k + 1];
        end

        gcdm_cell #(
            .DW (DW)
        ) u_cell (
            .clk      (clk),
            .shift_en (b_reg.valid),
            .inject   (32'(cols_reg) == k),
            .din      (d_new),
            .nbr      (nbr),
            .q        (chain_q[k])
        );
    end

    // ------------------------------------------------------------------
    // Distance step: one cell per cycle
    // ------------------------------------------------------------------
    function automatic logic [DW-1:0] step_up(input logic [DW-1:0] x);
        return (x == FAR) ? FAR : (x + DW'(1));
    endfunction

    // neighbor masks: cell 0 and the side neighbor sit toward column zero in
    // the forward sweep and toward the last column in the backward sweep
    assign m0 = b_reg.fwd ? !b_reg.lo : !b_reg.hi;
    assign m2 = b_reg.fwd ? !b_reg.hi : !b_reg.lo;

    always_comb
    begin
        if (b_reg.fwd)
            base_d = cell_rd ? '0 : FAR;
        else
            base_d = dist_rd;

        cand_v = b_reg.edge_v          ? FAR : step_up(chain_q[1]);
        cand_0 = (b_reg.edge_v || !m0) ? FAR : step_up(chain_q[0]);
        cand_2 = (b_reg.edge_v || !m2) ? FAR : step_up(chain_q[2]);
        cand_s = !m0                   ? FAR : step_up(left_reg);

        d_new = base_d;
        if (cand_v < d_new)
            d_new = cand_v;
        if (cand_0 < d_new)
            d_new = cand_0;
        if (cand_2 < d_new)
            d_new = cand_2;
        if (cand_s < d_new)
            d_new = cand_s;
    end

    // ------------------------------------------------------------------
    // Result encoding: -1 when nothing is empty or nothing is marked
    // ------------------------------------------------------------------
    always_comb
    begin
        if (!any_empty_reg || (best_reg == FAR))
            result = gcdm_pkg::OUT_NONE;
        else if (32'(best_reg) > gcdm_pkg::OUT_CAP)
            result = gcdm_pkg::OUT_W'(gcdm_pkg::OUT_CAP);
        else
            result = gcdm_pkg::OUT_W'(best_reg);
    end

    assign out_valid    = out_valid_reg;
    assign max_distance = out_data_reg;

endmodule
